// ===== rtl/slb_pkg.sv =====
// Shared types, codes and keyboard tables for the scan code line buffer.
package slb_pkg;

    localparam int RING_DEPTH_DEF = 1024;
    localparam int LINE_MAX_DEF   = 64;

    // Command codes
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Result kinds
    localparam logic [2:0] K_NONE      = 3'd0;
    localparam logic [2:0] K_BACKSPACE = 3'd1;
    localparam logic [2:0] K_TYPED     = 3'd2;
    localparam logic [2:0] K_LINECHAR  = 3'd3;
    localparam logic [2:0] K_LINEEND   = 3'd4;
    localparam logic [2:0] K_READCHAR  = 3'd5;
    localparam logic [2:0] K_READEMPTY = 3'd6;

    // Set-1 scan codes
    localparam logic [7:0] SC_ENTER     = 8'h1C;
    localparam logic [7:0] SC_BKSP      = 8'h0E;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
    localparam logic [7:0] SC_CAPS      = 8'h3A;
    localparam logic [7:0] SC_TOP       = 8'd58;

    localparam logic [6:0] CASE_DELTA = 7'd32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic       cmd;
        logic [7:0] key_code;
    } t_in_word;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] character;
        logic       last;
    } t_out_word;

    // Unshifted table, padded to 64 entries; only codes up to SC_TOP are looked up
    localparam logic [6:0] PLAIN_MAP [0:63] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [6:0] SHIFT_MAP [0:63] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

// ===== rtl/slb_keymap.sv =====
// Scan code to ASCII lookup with shift and caps lock.
module slb_keymap
    import slb_pkg::*;
(
    input  logic [7:0] i_code,
    input  logic       i_shift,
    input  logic       i_caps,
    output logic [6:0] o_char
);

    logic [6:0] base_char;

    always_comb begin
        base_char = 7'd0;
        if (i_code <= SC_TOP) begin
            base_char = i_shift ? SHIFT_MAP[i_code[5:0]] : PLAIN_MAP[i_code[5:0]];
        end
    end

    // swap letter case while caps lock is on
    always_comb begin
        o_char = base_char;
        if (i_caps) begin
            if (base_char >= 7'h61 && base_char <= 7'h7A) begin
                o_char = base_char - CASE_DELTA;
            end else if (base_char >= 7'h41 && base_char <= 7'h5A) begin
                o_char = base_char + CASE_DELTA;
            end
        end
    end

endmodule

// ===== rtl/slb_ring.sv =====
// Character ring memory: one write port, one registered read port, write-first.
module slb_ring
    import slb_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF,
    parameter int PTR_W = $clog2(RING_DEPTH_DEF)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [PTR_W-1:0] i_waddr,
    input  logic [6:0]       i_wdata,
    input  logic [PTR_W-1:0] i_raddr,
    output logic [6:0]       o_rdata
);

    logic [6:0] mem [DEPTH];
    logic [6:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // forward the word being written when it lands on the read address
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/scancode_line_buffer.sv =====
// Top level: set-1 scan codes to ASCII with a character ring and line drain.
//
// One input word is taken at a time. A scan code or read request is accepted
// when the block is idle and answered from the execute state, which waits
// while the output is stalled. Enter streams the buffered line out of the
// ring memory at one character per cycle while the output is not stalled
// (at most LINE_MAX-1 characters, then the line end), limited by the single
// read port of the ring. The ring read address always follows the next read
// pointer, so the head character is ready without an extra read cycle. The
// ring needs no clearing after reset; entries are read only once written.
module scancode_line_buffer
    import slb_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int LINE_MAX   = LINE_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int TAKE_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

    t_state            r_state, n_state;
    t_in_word          r_in;
    logic              r_shift, n_shift;
    logic              r_caps, n_caps;
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [TAKE_W-1:0] r_taken, n_taken;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;

    logic              in_acc;
    logic              out_free;
    logic              drain_more;
    logic              mem_we;
    logic [6:0]        map_char;
    logic [6:0]        rd_data;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [PTR_W-1:0]  rd_ptr_inc;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign drain_more = (r_rd_ptr != r_wr_ptr) && (r_taken != TAKE_W'(LINE_MAX - 1));
    assign wr_ptr_inc = ptr_next(r_wr_ptr);
    assign rd_ptr_inc = ptr_next(r_rd_ptr);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    slb_keymap u_keymap (
        .i_code  (r_in.key_code),
        .i_shift (r_shift),
        .i_caps  (r_caps),
        .o_char  (map_char)
    );

    slb_ring #(
        .DEPTH (RING_DEPTH),
        .PTR_W (PTR_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (map_char),
        .i_raddr (n_rd_ptr),
        .o_rdata (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    if (r_in.cmd == CMD_SCAN && r_in.key_code == SC_ENTER) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DRAIN: begin
                if (out_free && !drain_more) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_shift     = r_shift;
        n_caps      = r_caps;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_taken     = r_taken;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        mem_we      = 1'b0;
        case (r_state)
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '{kind: K_NONE, character: 7'd0, last: 1'b1};
                    if (r_in.cmd == CMD_READ) begin
                        if (r_rd_ptr == r_wr_ptr) begin
                            n_out_word.kind = K_READEMPTY;
                        end else begin
                            n_out_word.kind      = K_READCHAR;
                            n_out_word.character = rd_data;
                            n_rd_ptr             = rd_ptr_inc;
                        end
                    end else begin
                        case (r_in.key_code)
                            SC_ENTER: begin
                                // results come from the drain
                                n_out_valid = r_out_valid && i_out_stall;
                                n_out_word  = r_out_word;
                                n_taken     = '0;
                            end
                            SC_BKSP: begin
                                n_out_word.kind = K_BACKSPACE;
                            end
                            SC_LSHIFT, SC_RSHIFT: begin
                                n_shift = 1'b1;
                            end
                            SC_LSHIFT_UP, SC_RSHIFT_UP: begin
                                n_shift = 1'b0;
                            end
                            SC_CAPS: begin
                                n_caps = !r_caps;
                            end
                            default: begin
                                if (map_char != 7'd0) begin
                                    mem_we               = 1'b1;
                                    n_wr_ptr             = wr_ptr_inc;
                                    n_out_word.kind      = K_TYPED;
                                    n_out_word.character = map_char;
                                    // full ring: drop the oldest character
                                    if (wr_ptr_inc == r_rd_ptr) begin
                                        n_rd_ptr = rd_ptr_inc;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (drain_more) begin
                        n_out_word = '{kind: K_LINECHAR, character: rd_data, last: 1'b0};
                        n_rd_ptr   = rd_ptr_inc;
                        n_taken    = r_taken + 1'b1;
                    end else begin
                        n_out_word = '{kind: K_LINEEND, character: 7'd0, last: 1'b1};
                        n_wr_ptr   = '0;
                        n_rd_ptr   = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shift     <= 1'b0;
            r_caps      <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_taken     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_shift     <= n_shift;
            r_caps      <= n_caps;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_taken     <= n_taken;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_word;
        end
        r_out_word <= n_out_word;
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_EXEC)
        else $error("accepted word did not start execution");

    a_typed_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_wr_ptr != r_rd_ptr)
        else $error("ring empty right after a typed character");

    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DRAIN |-> r_taken <= TAKE_W'(LINE_MAX - 1))
        else $error("line drain ran past its limit");

    a_line_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && out_free && !drain_more)
        |=> (r_wr_ptr == '0 && r_rd_ptr == '0 && r_state == S_IDLE
             && o_out_word.kind == K_LINEEND && o_out_word.last))
        else $error("line end did not empty the ring");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.kind <= K_READEMPTY)
        else $error("result kind out of range");

endmodule

// ===== verif/tb.sv =====
// Testbench for the scan code line buffer: queued keystrokes, own translation and ring tracking.
`timescale 1ns / 100ps

module tb;
    import slb_pkg::*;

    localparam int RING_SLOTS = RING_DEPTH_DEF;
    localparam int LINE_CAP   = LINE_MAX_DEF;

    // Key tables for set-1 codes 0 through 58
    localparam logic [7:0] KEY_PLAIN [0:58] = '{
        8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'd8,
        8'd9, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'd10,
        8'd0, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", "'", 8'h60, 8'd0,
        "\\", "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'd0,
        "*", 8'd0, " ", 8'd0
    };

    localparam logic [7:0] KEY_SHIFT [0:58] = '{
        8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'd8,
        8'd9, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'd10,
        8'd0, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", "\"", "~", 8'd0,
        "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'd0,
        "*", 8'd0, " ", 8'd0
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    t_in_word  pending_keys [$];
    t_out_word due_words [$];
    int        faults = 0;

    // Tracked keyboard and ring state
    bit         shift_down;
    bit         caps_on;
    logic [6:0] ring_mem [0:RING_SLOTS-1];
    int         ring_wr;
    int         ring_rd;

    scancode_line_buffer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    function automatic void due_word(logic [2:0] kind, logic [6:0] ch, logic fin);
        due_words.push_back(t_out_word'{kind: kind, character: ch, last: fin});
    endfunction

    function automatic logic [6:0] key_char(logic [7:0] code);
        logic [6:0] c;
        if (code > SC_TOP) return 7'd0;
        c = shift_down ? KEY_SHIFT[code[5:0]][6:0] : KEY_PLAIN[code[5:0]][6:0];
        if (caps_on) begin
            if (c >= 7'h61 && c <= 7'h7A) c = c - CASE_DELTA;
            else if (c >= 7'h41 && c <= 7'h5A) c = c + CASE_DELTA;
        end
        return c;
    endfunction

    function automatic void keyboard_translate(t_in_word w);
        logic [6:0] c;
        int taken;
        taken = 0;
        if (w.cmd == CMD_READ) begin
            if (ring_wr == ring_rd) begin
                due_word(K_READEMPTY, 7'd0, 1'b1);
            end else begin
                due_word(K_READCHAR, ring_mem[ring_rd], 1'b1);
                ring_rd = (ring_rd + 1) % RING_SLOTS;
            end
        end else if (w.key_code == SC_ENTER) begin
            while (ring_rd != ring_wr && taken < LINE_CAP - 1) begin
                due_word(K_LINECHAR, ring_mem[ring_rd], 1'b0);
                ring_rd = (ring_rd + 1) % RING_SLOTS;
                taken++;
            end
            due_word(K_LINEEND, 7'd0, 1'b1);
            ring_wr = 0;
            ring_rd = 0;
        end else if (w.key_code == SC_BKSP) begin
            due_word(K_BACKSPACE, 7'd0, 1'b1);
        end else if (w.key_code == SC_LSHIFT || w.key_code == SC_RSHIFT) begin
            shift_down = 1'b1;
            due_word(K_NONE, 7'd0, 1'b1);
        end else if (w.key_code == SC_LSHIFT_UP || w.key_code == SC_RSHIFT_UP) begin
            shift_down = 1'b0;
            due_word(K_NONE, 7'd0, 1'b1);
        end else if (w.key_code == SC_CAPS) begin
            caps_on = !caps_on;
            due_word(K_NONE, 7'd0, 1'b1);
        end else begin
            c = key_char(w.key_code);
            if (c != 7'd0) begin
                ring_mem[ring_wr] = c;
                ring_wr = (ring_wr + 1) % RING_SLOTS;
                // full ring: drop the oldest character
                if (ring_wr == ring_rd) ring_rd = (ring_rd + 1) % RING_SLOTS;
                due_word(K_TYPED, c, 1'b1);
            end else begin
                due_word(K_NONE, 7'd0, 1'b1);
            end
        end
    endfunction

    function automatic void push_scan(logic [7:0] code);
        pending_keys.push_back(t_in_word'{cmd: CMD_SCAN, key_code: code});
    endfunction

    // Read requests carry random code bits, which the block must ignore
    function automatic void push_read();
        pending_keys.push_back(t_in_word'{cmd: CMD_READ, key_code: 8'($urandom_range(0, 255))});
    endfunction

    function automatic logic [7:0] typed_code();
        logic [7:0] code;
        do code = 8'($urandom_range(1, 57)); while (code == SC_ENTER);
        return code;
    endfunction

    // Input side: hold each word until taken, then wait a drawn gap
    always @(posedge i_clk) begin : drive
        int gap;
        int sent;
        bit calm;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap = 0;
        end else if (i_in_valid && !o_in_stall) begin
            keyboard_translate(i_in_word);
            sent++;
            if (sent % 32 == 0) calm = ($urandom_range(0, 3) == 0);
            if (calm || gap == 0) gap = 0;
            gap = calm ? 0 : $urandom_range(0, 13);
            if (gap == 0 && pending_keys.size() != 0) begin
                i_in_word <= pending_keys.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid) begin
            if (gap > 1) begin
                gap--;
            end else if (pending_keys.size() != 0) begin
                gap = 0;
                i_in_word  <= pending_keys.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // Output side: check each taken word, then stall for a drawn count
    always @(posedge i_clk) begin : watch
        t_out_word want;
        int hold;
        int seen;
        bit calm;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold = 0;
        end else if (o_out_valid && !i_out_stall) begin
            if (due_words.size() == 0) begin
                $error("unexpected word: kind %0d character %0h last %0b",
                       o_out_word.kind, o_out_word.character, o_out_word.last);
                faults++;
            end else begin
                want = due_words.pop_front();
                if (o_out_word.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_out_word.kind);
                    faults++;
                end
                if (o_out_word.character !== want.character) begin
                    $error("character: expected %0h, got %0h",
                           want.character, o_out_word.character);
                    faults++;
                end
                if (o_out_word.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_out_word.last);
                    faults++;
                end
            end
            seen++;
            if (seen % 32 == 0) calm = ($urandom_range(0, 3) == 0);
            hold = calm ? 0 : $urandom_range(0, 13);
            i_out_stall <= (hold != 0);
        end else if (hold != 0) begin
            hold--;
            i_out_stall <= (hold != 0);
        end
    end

    initial begin
        int made;
        int len;
        int r;
        shift_down = 1'b0;
        caps_on    = 1'b0;
        ring_wr    = 0;
        ring_rd    = 0;
        made       = 0;

        // directed: empty read and empty line first
        push_read();
        push_scan(SC_ENTER);
        push_scan(8'h00);
        push_scan(8'h1E);
        push_scan(SC_LSHIFT);
        push_scan(8'h1E);
        push_scan(8'h02);
        push_scan(SC_LSHIFT_UP);
        push_scan(SC_CAPS);
        push_scan(8'h1E);
        push_scan(SC_RSHIFT);
        push_scan(8'h10);
        push_scan(SC_RSHIFT_UP);
        push_scan(SC_CAPS);
        push_scan(SC_BKSP);
        push_scan(8'hFF);
        push_scan(8'h3B);
        push_scan(8'h39);
        push_scan(8'h9E);
        push_scan(8'h01);
        push_scan(8'h0F);
        pending_keys.push_back(t_in_word'{cmd: CMD_READ, key_code: SC_ENTER});
        push_scan(SC_ENTER);

        // type a long line, read a few back, then end it
        repeat (70) push_scan(typed_code());
        repeat (4) push_read();
        push_scan(SC_ENTER);

        while (made < 150) begin
            if ($urandom_range(0, 9) == 0) begin
                pending_keys.push_back(t_in_word'{cmd: 1'($urandom_range(0, 1)),
                                                  key_code: 8'($urandom_range(0, 255))});
                made++;
            end else begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 80)
                                                  : $urandom_range(0, 20);
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 19);
                    if (r == 0) push_scan(SC_CAPS);
                    else if (r == 1) push_scan($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT);
                    else if (r == 2)
                        push_scan($urandom_range(0, 1) ? SC_LSHIFT_UP : SC_RSHIFT_UP);
                    else if (r == 3) push_read();
                    else if (r == 4) push_scan(SC_BKSP);
                    else push_scan(typed_code());
                end
                // leave some lines open so characters carry into the next one
                if ($urandom_range(0, 7) != 0) push_scan(SC_ENTER);
                made += len + 1;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_keys.size() != 0 || i_in_valid) @(negedge i_clk);
        while (due_words.size() != 0) @(negedge i_clk);
        repeat (80) @(posedge i_clk);

        if (faults == 0 && due_words.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/slb_pkg.sv
rtl/slb_keymap.sv
rtl/slb_ring.sv
rtl/scancode_line_buffer.sv
verif/tb.sv
